[rtl/dlgk_pkg.sv]
// Shared types and constants for the dB to linear gain converter.
package dlgk_pkg;

  // Field widths
  localparam int LEVEL_W = 16;              // level and floor, 1/256 dB
  localparam int KNEE_W  = LEVEL_W + 1;     // knee point never wraps
  localparam int GAIN_W  = 20;              // output gain width
  localparam int D_W     = 12;              // distance above floor on the line
  localparam int FRAC_W  = 24;              // exponent fraction bits (octaves)
  localparam int EXP_W   = 30;              // exponent product, signed
  localparam int OCT_W   = EXP_W - FRAC_W;  // integer octave, signed
  localparam int MANT_W  = 32;              // Q30 mantissa container
  localparam int MANT_FRAC = 30;
  localparam int DT_W    = 28;              // table step width
  localparam int TAYLOR_TERMS = 24;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  // Knee offset: 20/ln10 dB in 1/256 dB, and log2(10)/20 in Q16
  localparam int KNEE_Q8 = 2224;
  localparam int L2_Q16  = 10885;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // Shifts at or past this width always round to zero
  localparam int SH_ZERO = MANT_W + 1;

  // Division by KNEE_Q8 = 16 * 139: shift by four, then reciprocal multiply
  localparam int KNEE_PRE   = 4;
  localparam int KNEE_ODD   = KNEE_Q8 / 16;
  localparam int RECIP_SHIFT = 37;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + KNEE_ODD - 1) / KNEE_ODD;
  localparam int LINE_W  = 2 * GAIN_W - 8;   // d * gk product width (32)
  localparam int QIN_W   = LINE_W + 1 - KNEE_PRE;
  localparam int RPROD_W = QIN_W + 30;

  // Per-item routing info that rides along the pipeline
  typedef struct packed {
    logic           in_knee;
    logic           below;
    logic [D_W-1:0] d;
  } dlgk_side_t;

endpackage

[rtl/dlgk_exp_path.sv]
// Five-stage power-of-two gain path: exponent, table index, lookup, interpolation, shift.
module dlgk_exp_path #(
  parameter int TABLE_ENTRIES  = 64,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic [4:0]                          en,
  input  logic signed [dlgk_pkg::KNEE_W-1:0]  x,
  input  dlgk_pkg::dlgk_side_t                side_in,
  output logic [dlgk_pkg::GAIN_W-1:0]         gk,
  output logic                                clip,
  output dlgk_pkg::dlgk_side_t                side_out
);
  import dlgk_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int TW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW = FRAC_W + IW;

  typedef logic [MANT_W-1:0] pow_tab_t [TABLE_ENTRIES+1];

  // 2^(i/N) in Q30 from a truncated Taylor series of exp
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t tab;
    longint unsigned z;
    longint unsigned term;
    longint unsigned sum;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      z    = (64'(i) * LN2_Q30) / TABLE_ENTRIES;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = ((term * z) >> MANT_FRAC) / 64'(k);
        sum  = sum + term;
      end
      tab[i] = MANT_W'(sum);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

  dlgk_side_t side_r [5];

  logic signed [OCT_W-1:0] n1, n2, n3, n4;
  logic [FRAC_W-1:0]       f1, r2, r3;
  logic [IW-1:0]           idx2;
  logic [MANT_W-1:0]       t03, t04;
  logic [DT_W-1:0]         dt3, frac4;

  // Stage 1: exponent in Q24 octaves
  logic signed [31:0] e_full;
  assign e_full = $signed({{(32-KNEE_W){x[KNEE_W-1]}}, x}) * 32'sd10885;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n1 <= e_full[EXP_W-1:FRAC_W];
      f1 <= e_full[FRAC_W-1:0];
      side_r[0] <= side_in;
    end
  end

  // Stage 2: fraction scaled to table positions
  logic [PW-1:0] p;
  assign p = PW'(f1) * PW'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      idx2 <= p[PW-1:FRAC_W];
      r2   <= p[FRAC_W-1:0];
      n2   <= n1;
      side_r[1] <= side_r[0];
    end
  end

  // Stage 3: table lookup of both neighbors
  logic [TW-1:0]     ia, ib;
  logic [MANT_W-1:0] ta, tb, tdiff;
  assign ia    = TW'(idx2);
  assign ib    = ia + TW'(1);
  assign ta    = POW_TAB[ia];
  assign tb    = POW_TAB[ib];
  assign tdiff = tb - ta;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t03 <= ta;
      dt3 <= tdiff[DT_W-1:0];
      r3  <= r2;
      n3  <= n2;
      side_r[2] <= side_r[1];
    end
  end

  // Stage 4: interpolation product
  logic [DT_W+FRAC_W-1:0] iprod;
  assign iprod = (DT_W+FRAC_W)'(dt3) * (DT_W+FRAC_W)'(r3);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      frac4 <= iprod[DT_W+FRAC_W-1:FRAC_W];
      t04   <= t03;
      n4    <= n3;
      side_r[3] <= side_r[2];
    end
  end

  // Stage 5: mantissa, rounding shift and saturation
  logic [MANT_W-1:0]   m;
  logic signed [7:0]   s;
  logic [7:0]          sh;
  logic [MANT_W+1:0]   rnd;
  logic [MANT_W+1:0]   g;
  logic [GAIN_W-1:0]   gk_next;
  logic                clip_next;

  always_comb begin
    m   = t04 + MANT_W'(frac4);
    s   = {{(8-OCT_W){n4[OCT_W-1]}}, n4} + 8'(GAIN_FRAC_BITS - MANT_FRAC);
    sh  = 8'(-s);
    rnd = (MANT_W+2)'(m) + ((MANT_W+2)'(1) << (sh - 8'd1));
    g   = rnd >> sh[5:0];
    gk_next   = '0;
    clip_next = 1'b0;
    if (!s[7]) begin
      gk_next   = GAIN_MAX;
      clip_next = 1'b1;
    end else if (sh >= 8'(SH_ZERO)) begin
      gk_next = '0;
    end else if (g > (MANT_W+2)'(GAIN_MAX)) begin
      gk_next   = GAIN_MAX;
      clip_next = 1'b1;
    end else begin
      gk_next = g[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      gk   <= gk_next;
      clip <= clip_next;
      side_r[4] <= side_r[3];
    end
  end

  assign side_out = side_r[4];

endmodule

[rtl/dlgk_knee_line.sv]
// Two-stage linear segment below the knee: d * gk, then rounded divide by the knee width.
module dlgk_knee_line (
  input  logic                        clk,
  input  logic [1:0]                  en,
  input  logic [dlgk_pkg::GAIN_W-1:0] gk_in,
  input  logic                        clip_in,
  input  dlgk_pkg::dlgk_side_t        side_in,
  output logic [dlgk_pkg::GAIN_W-1:0] q,
  output logic [dlgk_pkg::GAIN_W-1:0] gk_out,
  output logic                        clip_out,
  output dlgk_pkg::dlgk_side_t        side_out
);
  import dlgk_pkg::*;

  logic [LINE_W-1:0] v;
  logic [GAIN_W-1:0] gk6;
  logic              clip6;
  dlgk_side_t        side6;

  // Stage 6: distance times knee gain
  logic [LINE_W-1:0] v_next;
  assign v_next = LINE_W'(side_in.d) * LINE_W'(gk_in);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v     <= v_next;
      gk6   <= gk_in;
      clip6 <= clip_in;
      side6 <= side_in;
    end
  end

  // Stage 7: round half up, divide by 16, then reciprocal of 139
  logic [LINE_W:0]    u;
  logic [QIN_W-1:0]   u4;
  logic [RPROD_W-1:0] rprod;
  assign u     = (LINE_W+1)'(v) + (LINE_W+1)'(KNEE_Q8 / 2);
  assign u4    = u[LINE_W:KNEE_PRE];
  assign rprod = RPROD_W'(u4) * RPROD_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q        <= rprod[RECIP_SHIFT +: GAIN_W];
      gk_out   <= gk6;
      clip_out <= clip6;
      side_out <= side6;
    end
  end

endmodule

[rtl/db_to_linear_gain_knee_top.sv]
// Top level: front stage, pipeline flow control, output register and floor register.
// Pipeline of 8 internal stages plus the output register; one item per cycle is
// sustained while out_stall is low. Each stage holds its item under output stall
// and fills bubbles; the 8-stage knee/exponent/lookup/interpolate/shift/line chain
// sets the latency.
// Reset (rst, synchronous) empties the pipeline and sets the floor register to -70 dB.
module db_to_linear_gain_knee_top #(
  parameter int TABLE_ENTRIES  = 64,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dlgk_pkg::LEVEL_W-1:0]  level_db,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dlgk_pkg::GAIN_W-1:0]          gain,
  output logic                                 in_knee,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic signed [dlgk_pkg::LEVEL_W-1:0]  floor_level
);
  import dlgk_pkg::*;

  localparam int NS = 8;

  logic signed [LEVEL_W-1:0] floor_r;
  logic [NS-1:0]             stg_v;
  logic [NS-1:0]             stg_rdy;
  logic                      out_rdy;

  // Floor register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_r <= -16'sd17920;
    end else if (cfg_valid) begin
      floor_r <= floor_level;
    end
  end

  // Flow control: a stage loads when empty or when the next one moves
  always_comb begin
    out_rdy = !out_valid || !out_stall;
    stg_rdy[NS-1] = !stg_v[NS-1] || out_rdy;
    for (int k = NS - 2; k >= 0; k--) begin
      stg_rdy[k] = !stg_v[k] || stg_rdy[k+1];
    end
  end

  assign in_stall = !stg_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (stg_rdy[0]) begin
        stg_v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (stg_rdy[k]) begin
          stg_v[k] <= stg_v[k-1];
        end
      end
      if (out_rdy) begin
        out_valid <= stg_v[NS-1];
      end
    end
  end

  // Stage 0: knee point, path choice, exponent source
  logic signed [KNEE_W-1:0] lvl_x, flr_x, knee, diff;
  logic signed [KNEE_W-1:0] x0;
  dlgk_side_t               side0;
  dlgk_side_t               side0_next;
  logic signed [KNEE_W-1:0] x0_next;

  always_comb begin
    lvl_x = {level_db[LEVEL_W-1], level_db};
    flr_x = {floor_r[LEVEL_W-1], floor_r};
    knee  = flr_x + KNEE_W'(KNEE_Q8);
    diff  = lvl_x - flr_x;
    side0_next.in_knee = lvl_x < knee;
    side0_next.below   = lvl_x < flr_x;
    side0_next.d       = diff[D_W-1:0];
    x0_next = side0_next.in_knee ? knee : lvl_x;
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      x0    <= x0_next;
      side0 <= side0_next;
    end
  end

  // Stages 1-5: log path gain
  logic [GAIN_W-1:0] gk5;
  logic              clip5;
  dlgk_side_t        side5;

  dlgk_exp_path #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_exp (
    .clk      (clk),
    .en       (stg_rdy[5:1]),
    .x        (x0),
    .side_in  (side0),
    .gk       (gk5),
    .clip     (clip5),
    .side_out (side5)
  );

  // Stages 6-7: linear segment below the knee
  logic [GAIN_W-1:0] q7, gk7;
  logic              clip7;
  dlgk_side_t        side7;

  dlgk_knee_line u_line (
    .clk      (clk),
    .en       (stg_rdy[7:6]),
    .gk_in    (gk5),
    .clip_in  (clip5),
    .side_in  (side5),
    .q        (q7),
    .gk_out   (gk7),
    .clip_out (clip7),
    .side_out (side7)
  );

  // Output register: pick the path and the flags
  logic [GAIN_W-1:0] gain_next;
  always_comb begin
    if (side7.below) begin
      gain_next = '0;
    end else if (side7.in_knee) begin
      gain_next = q7;
    end else begin
      gain_next = gk7;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      gain      <= gain_next;
      in_knee   <= side7.in_knee;
      saturated <= side7.below || clip7;
    end
  end

  // Assertions
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&stg_v) && out_valid)
    else $error("input stalled while the pipeline has a bubble");

  a_log_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated && !in_knee |-> gain == GAIN_MAX)
    else $error("clipped log-path item without full-scale gain");

  a_line_le_knee: assert property (@(posedge clk) disable iff (rst)
    stg_v[NS-1] && side7.in_knee && !side7.below |-> q7 <= gk7)
    else $error("line gain above knee gain");

endmodule
